// File: src/dstq_pkg.sv
// shared types and constants for the deadline sorted timer queue
package dstq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 48;
    localparam int DELAY_W     = 32;
    localparam int TAG_W       = 16;
    localparam int ARG_W       = 32;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [TIME_W-1:0] TIME_NONE = {TIME_W{1'b1}};

    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_SERVICE = 1'b1;

    localparam logic [1:0] KIND_ENQ   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_ALARM = 2'd2;

    // classified command passed from front to back
    typedef struct packed {
        logic              service;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
        logic [ARG_W-1:0]  arg_first;
        logic [ARG_W-1:0]  arg_second;
    } cmd_t;

    // stored event
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
        logic [ARG_W-1:0]  arg_first;
        logic [ARG_W-1:0]  arg_second;
    } entry_t;

endpackage

// File: src/dstq_front.sv
// front part: takes command words, computes saturated deadlines, feeds the queue
module dstq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               func,
    input  logic [47:0]        now_ms,
    input  logic [31:0]        timeout_ms,
    input  logic [15:0]        handler_tag,
    input  logic [31:0]        arg_first,
    input  logic [31:0]        arg_second,
    input  logic               cmd_ready,
    output logic               cmd_valid,
    output dstq_pkg::cmd_t     cmd
);

    logic                 cmd_valid_reg, cmd_valid_next;
    dstq_pkg::cmd_t       cmd_reg;
    logic [48:0]          sum;
    logic [47:0]          dl;
    logic                 take;

    // saturating deadline
    always_comb
    begin
        sum = {1'b0, now_ms} + {17'd0, timeout_ms};
        dl  = sum[48] ? dstq_pkg::TIME_NONE : sum[47:0];
    end

    assign take = start && (!cmd_valid_reg || cmd_ready);

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
        if (take)
        begin
            cmd_valid_next = 1'b1;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.service    <= (func == dstq_pkg::FUNC_SERVICE);
            cmd_reg.now_ms     <= now_ms;
            cmd_reg.deadline   <= dl;
            cmd_reg.tag        <= handler_tag;
            cmd_reg.arg_first  <= arg_first;
            cmd_reg.arg_second <= arg_second;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: src/dstq_fifo.sv
// short command queue between front and back
module dstq_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dstq_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output dstq_pkg::cmd_t out_cmd
);

    localparam int PTR_W = $clog2(dstq_pkg::FIFO_DEPTH);

    dstq_pkg::cmd_t          mem [dstq_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]        wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0]          cnt_reg, cnt_next;
    logic                    push, pop;

    assign in_ready  = (cnt_reg != dstq_pkg::FIFO_DEPTH[PTR_W:0]);
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem[rd_reg];

    // pointer update
    always_comb
    begin
        wr_next  = push ? PTR_W'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? PTR_W'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_cmd;
        end
    end

endmodule

// File: src/dstq_back.sv
// back part: sorted event memory, insert and drain sequencer, result words
module dstq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  dstq_pkg::cmd_t cmd,
    output logic           strobe,
    output logic [1:0]     kind,
    output logic           accepted,
    output logic [15:0]    fired_tag,
    output logic [31:0]    fired_arg_first,
    output logic [31:0]    fired_arg_second,
    output logic           program_alarm,
    output logic [47:0]    alarm_time,
    output logic           last
);

    localparam int IW = dstq_pkg::IDX_W;
    localparam int CW = dstq_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_DRAIN,
        ST_COMPACT,
        ST_HEAD,
        ST_DONE
    } state_t;

    // event memory, single write port, one registered read port
    dstq_pkg::entry_t mem [dstq_pkg::QUEUE_DEPTH];
    dstq_pkg::entry_t rd_data_reg;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    dstq_pkg::entry_t wr_data;

    state_t            state_reg;
    dstq_pkg::cmd_t    cur_reg;
    logic [CW-1:0]     count_reg;
    logic [47:0]       alarm_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     pop_reg;
    logic              rd_ok_reg;

    logic              strobe_reg;
    logic [1:0]        kind_reg;
    logic              acc_reg;
    logic [15:0]       tag_reg;
    logic [31:0]       a1_reg, a2_reg;
    logic              prog_reg;
    logic [47:0]       atime_reg;
    logic              last_reg;

    dstq_pkg::entry_t  new_entry;

    assign new_entry = '{deadline: cur_reg.deadline, tag: cur_reg.tag,
                         arg_first: cur_reg.arg_first, arg_second: cur_reg.arg_second};

    // read address chosen by the sequencer
    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = new_entry;
        unique case (state_reg)
            ST_SEARCH:  rd_addr = idx_reg[IW-1:0];
            ST_SHIFT:   rd_addr = IW'(idx_reg - 1'b1);
            ST_DRAIN:   rd_addr = idx_reg[IW-1:0];
            ST_COMPACT: rd_addr = IW'(idx_reg + pop_reg);
            default:    rd_addr = '0;
        endcase
        // writes issued in the cycle after the read
        if (state_reg == ST_SHIFT && rd_ok_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg[IW-1:0];
            wr_data = rd_data_reg;
        end
        else if (state_reg == ST_COMPACT && rd_ok_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = IW'(idx_reg - 1'b1);
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == ST_SHIFT && idx_reg == pos_reg && !rd_ok_reg)
        begin
            mem[pos_reg[IW-1:0]] <= new_entry;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            count_reg  <= '0;
            alarm_reg  <= dstq_pkg::TIME_NONE;
            idx_reg    <= '0;
            pos_reg    <= '0;
            pop_reg    <= '0;
            rd_ok_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            kind_reg   <= '0;
            acc_reg    <= 1'b0;
            tag_reg    <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
            prog_reg   <= 1'b0;
            atime_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg   <= cmd;
                        idx_reg   <= '0;
                        pop_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        if (cmd.service)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else if (count_reg == CW'(dstq_pkg::QUEUE_DEPTH))
                        begin
                            strobe_reg <= 1'b1;
                            kind_reg   <= dstq_pkg::KIND_ENQ;
                            acc_reg    <= 1'b0;
                            tag_reg    <= '0;
                            a1_reg     <= '0;
                            a2_reg     <= '0;
                            prog_reg   <= 1'b0;
                            atime_reg  <= alarm_reg;
                            last_reg   <= 1'b1;
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    // rd_data_reg holds entry idx_reg-1 when rd_ok_reg
                    if (rd_ok_reg && ((idx_reg == CW'(1))
                            ? !(cur_reg.deadline < rd_data_reg.deadline)
                            : (rd_data_reg.deadline < cur_reg.deadline)))
                    begin
                        // keep walking, or insert at the end once every entry is passed
                        if (idx_reg == count_reg)
                        begin
                            pos_reg   <= idx_reg;
                            idx_reg   <= count_reg;
                            rd_ok_reg <= 1'b0;
                            state_reg <= ST_SHIFT;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else if (rd_ok_reg || count_reg == '0)
                    begin
                        pos_reg   <= (count_reg == '0) ? '0 : CW'(idx_reg - 1'b1);
                        idx_reg   <= count_reg;
                        rd_ok_reg <= 1'b0;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b1;
                        idx_reg   <= idx_reg + 1'b1;
                    end
                end
                ST_SHIFT:
                begin
                    // read idx-1, write to idx next cycle; then drop in new entry
                    if (rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b0;
                        idx_reg   <= idx_reg - 1'b1;
                    end
                    else if (idx_reg != pos_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg  <= count_reg + 1'b1;
                        strobe_reg <= 1'b1;
                        kind_reg   <= dstq_pkg::KIND_ENQ;
                        acc_reg    <= 1'b1;
                        tag_reg    <= '0;
                        a1_reg     <= '0;
                        a2_reg     <= '0;
                        last_reg   <= 1'b1;
                        if (pos_reg == '0 && cur_reg.deadline < alarm_reg)
                        begin
                            alarm_reg <= cur_reg.deadline;
                            prog_reg  <= 1'b1;
                            atime_reg <= cur_reg.deadline;
                        end
                        else
                        begin
                            prog_reg  <= 1'b0;
                            atime_reg <= alarm_reg;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DRAIN:
                begin
                    // read entry idx, judge it next cycle
                    if (!rd_ok_reg)
                    begin
                        if (idx_reg == count_reg)
                        begin
                            pop_reg   <= idx_reg;
                            idx_reg   <= '0;
                            state_reg <= ST_COMPACT;
                        end
                        else
                        begin
                            rd_ok_reg <= 1'b1;
                        end
                    end
                    else if (rd_data_reg.deadline <= cur_reg.now_ms)
                    begin
                        strobe_reg <= 1'b1;
                        kind_reg   <= dstq_pkg::KIND_FIRED;
                        acc_reg    <= 1'b0;
                        tag_reg    <= rd_data_reg.tag;
                        a1_reg     <= rd_data_reg.arg_first;
                        a2_reg     <= rd_data_reg.arg_second;
                        prog_reg   <= 1'b0;
                        atime_reg  <= '0;
                        last_reg   <= 1'b0;
                        idx_reg    <= idx_reg + 1'b1;
                        rd_ok_reg  <= 1'b0;
                    end
                    else
                    begin
                        pop_reg   <= idx_reg;
                        idx_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        state_reg <= ST_COMPACT;
                    end
                end
                ST_COMPACT:
                begin
                    // move entry idx+pop down to idx, one read then one write
                    if (rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b0;
                    end
                    else if (pop_reg != '0 && (idx_reg + pop_reg) < count_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                        idx_reg   <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg - pop_reg;
                        state_reg <= ST_HEAD;
                        rd_ok_reg <= 1'b0;
                    end
                end
                ST_HEAD:
                begin
                    // address 0 read is in flight during first head cycle
                    if (!rd_ok_reg)
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        strobe_reg <= 1'b1;
                        kind_reg   <= dstq_pkg::KIND_ALARM;
                        acc_reg    <= 1'b0;
                        tag_reg    <= '0;
                        a1_reg     <= '0;
                        a2_reg     <= '0;
                        last_reg   <= 1'b1;
                        if (count_reg != '0)
                        begin
                            alarm_reg <= rd_data_reg.deadline;
                            prog_reg  <= 1'b1;
                            atime_reg <= rd_data_reg.deadline;
                        end
                        else
                        begin
                            alarm_reg <= dstq_pkg::TIME_NONE;
                            prog_reg  <= 1'b0;
                            atime_reg <= dstq_pkg::TIME_NONE;
                        end
                        rd_ok_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe           = strobe_reg;
    assign kind             = kind_reg;
    assign accepted         = acc_reg;
    assign fired_tag        = tag_reg;
    assign fired_arg_first  = a1_reg;
    assign fired_arg_second = a2_reg;
    assign program_alarm    = prog_reg;
    assign alarm_time       = atime_reg;
    assign last             = last_reg;

endmodule

// File: src/deadline_sorted_timer_queue_top.sv
// top level of the deadline sorted timer queue
//
//  channel   handshake          fields
//  command   start / busy       func now_ms timeout_ms handler_tag arg_first arg_second
//  result    strobe (no stall)  kind accepted fired_* program_alarm alarm_time last
//
// an enqueue and a service each walk the stored events one entry a step, paced by
// the single read port of the event memory.
// reset clears the fill count and sets the alarm to none; no clearing pass.
// busy is high only while the front register and the two-word queue are full.
// results are shown for one cycle each and cannot be held off.
module deadline_sorted_timer_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [47:0] now_ms,
    input  logic [31:0] timeout_ms,
    input  logic [15:0] handler_tag,
    input  logic [31:0] arg_first,
    input  logic [31:0] arg_second,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic [15:0] fired_tag,
    output logic [31:0] fired_arg_first,
    output logic [31:0] fired_arg_second,
    output logic        program_alarm,
    output logic [47:0] alarm_time,
    output logic        last
);

    logic           f_valid, f_ready, q_valid, q_ready;
    dstq_pkg::cmd_t f_cmd, q_cmd;

    // front
    dstq_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func), .now_ms(now_ms),
        .timeout_ms(timeout_ms), .handler_tag(handler_tag), .arg_first(arg_first),
        .arg_second(arg_second), .cmd_ready(f_ready), .cmd_valid(f_valid), .cmd(f_cmd)
    );

    assign busy = f_valid && !f_ready;

    // queue
    dstq_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    // back
    dstq_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .strobe(strobe), .kind(kind), .accepted(accepted),
        .fired_tag(fired_tag), .fired_arg_first(fired_arg_first),
        .fired_arg_second(fired_arg_second), .program_alarm(program_alarm),
        .alarm_time(alarm_time), .last(last)
    );

endmodule
